// ----- src/multi_voice_audio_mixer_top_defines.svh -----
// ----------------------------------------------------------------------------
// multi_voice_audio_mixer_top_defines
// Assertion macros shared by the mixer's checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_VOICE_AUDIO_MIXER_TOP_DEFINES_SVH
`define MULTI_VOICE_AUDIO_MIXER_TOP_DEFINES_SVH

// implication checked while out of reset
`define MVAM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked while out of reset
`define MVAM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after reset is asserted
`define MVAM_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

// ----- src/mvam_pkg.sv -----
// ----------------------------------------------------------------------------
// mvam_pkg
// Types, format codes and constants of the multi-voice audio mixer.
// ----------------------------------------------------------------------------
package mvam_pkg;

  localparam int NUM_VOICES_DEF    = 16;
  localparam int POS_FRAC_BITS_DEF = 16;

  localparam int ACC_W  = 40;
  localparam int POS_W  = 40;
  localparam int PROD_W = 29;
  localparam int MIX_W  = 24;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic        [POS_W-1:0]  pos_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [MIX_W-1:0]  mix_t;

  // sample / mix format codes
  localparam logic [2:0] FMT_U8_MONO    = 3'd0;
  localparam logic [2:0] FMT_U8_STEREO  = 3'd1;
  localparam logic [2:0] FMT_S8_MONO    = 3'd2;
  localparam logic [2:0] FMT_S8_STEREO  = 3'd3;
  localparam logic [2:0] FMT_S16_MONO   = 3'd4;
  localparam logic [2:0] FMT_S16_STEREO = 3'd5;

  // register index
  localparam logic REG_MIX_FORMAT = 1'b0;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam acc_t MIX_MAX = 40'sd8388607;
  localparam acc_t MIX_MIN = -40'sd8388608;
  localparam logic [7:0] U8_BIAS = 8'd128;

endpackage

// ----- src/multi_voice_audio_mixer_top.sv -----
// ----------------------------------------------------------------------------
// multi_voice_audio_mixer_top
// Multi-voice saturating PCM mixer with per-voice resample positions.
// ----------------------------------------------------------------------------
// Takes one voice sample item per clock while in_ready is high (in_ready drops
// while a result is held by out_ready low) and returns one status item per input
// item. The item flows through three registered stages: the per-voice position
// memory is read at accept (a write from the previous item to the same voice is
// forwarded), the position is advanced and the sample scaled in the next stage,
// and the accumulators are updated in the last. The item with in_last_voice set
// carries the finished frame in out_left and out_right. Positions read as zero
// after reset through per-voice valid bits. mix_format is at byte address 0; the
// user must write it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module multi_voice_audio_mixer_top #(
  parameter int NUM_VOICES    = mvam_pkg::NUM_VOICES_DEF,
  parameter int POS_FRAC_BITS = mvam_pkg::POS_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_voice,
  input  logic        in_restart,
  input  logic [15:0] in_sample_a,
  input  logic [15:0] in_sample_b,
  input  logic [2:0]  in_source_format,
  input  logic [19:0] in_volume,
  input  logic [23:0] in_rate_step,
  input  logic [23:0] in_length,
  input  logic        in_last_voice,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_voice_echo,
  output logic [23:0] out_next_index,
  output logic        out_voice_done,
  output logic        out_frame_valid,
  output logic [15:0] out_left,
  output logic [15:0] out_right
);

  localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SH_L   = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;
  localparam int SH_R   = (POS_FRAC_BITS < 16) ? 16 - POS_FRAC_BITS : 0;

  // ---------------------------------------------------------------- config
  logic [2:0] mix_format_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == mvam_pkg::REG_MIX_FORMAT);
  assign prdata = (paddr[2] == mvam_pkg::REG_MIX_FORMAT) ? {29'd0, mix_format_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_format_r <= mvam_pkg::FMT_S16_STEREO;
    end else if (cfg_wr) begin
      mix_format_r <= pwdata[2:0];
    end
  end

  // ---------------------------------------------------------------- control
  logic c_valid_r;
  logic a_valid_r;
  logic b_valid_r;
  logic adv;
  logic in_acc;

  assign adv      = !c_valid_r || out_ready;
  assign in_ready = adv;
  assign in_acc   = in_valid && adv;

  // voice index modulo NUM_VOICES
  logic [VIDX_W-1:0] voice_map [16];
  logic [VIDX_W-1:0] vidx_in;

  for (genvar k = 0; k < 16; k++) begin : g_vmap
    assign voice_map[k] = VIDX_W'(k % NUM_VOICES);
  end
  assign vidx_in = voice_map[in_voice];

  // ---------------------------------------------------------------- stage A
  mvam_pkg::pos_t     pos_mem [NUM_VOICES];
  logic [NUM_VOICES-1:0] pos_vld_r;

  logic [3:0]         a_voice_r;
  logic [VIDX_W-1:0]  a_vidx_r;
  logic               a_restart_r;
  logic [15:0]        a_sa_r;
  logic [15:0]        a_sb_r;
  logic [2:0]         a_fmt_r;
  logic [19:0]        a_vol_r;
  logic [23:0]        a_step_r;
  logic [23:0]        a_len_r;
  logic               a_last_r;
  mvam_pkg::pos_t     a_rd_data_r;
  logic               a_rd_vld_r;
  logic               a_fwd_r;
  mvam_pkg::pos_t     a_fwd_data_r;

  mvam_pkg::pos_t     pos_cur;
  mvam_pkg::pos_t     pos_nxt;
  logic [31:0]        step_scaled;
  logic [40:0]        pos_sum;
  logic               active;
  logic               wr_en;

  logic signed [16:0] smp_l;
  logic signed [16:0] smp_r;
  logic signed [20:0] gain;
  logic               fmt_ok;
  logic signed [37:0] prod_l;
  logic signed [37:0] prod_r;

  assign wr_en = a_valid_r && adv;

  always_comb begin
    if (a_restart_r) begin
      pos_cur = '0;
    end else if (a_fwd_r) begin
      pos_cur = a_fwd_data_r;
    end else if (a_rd_vld_r) begin
      pos_cur = a_rd_data_r;
    end else begin
      pos_cur = '0;
    end
    step_scaled = (32'(a_step_r) << SH_L) >> SH_R;
    active      = (pos_cur >> POS_FRAC_BITS) < 40'(a_len_r);
    pos_sum     = {1'b0, pos_cur} + 41'(step_scaled);
    if (!active) begin
      pos_nxt = pos_cur;
    end else if (pos_sum[40]) begin
      pos_nxt = '1;
    end else begin
      pos_nxt = pos_sum[39:0];
    end
  end

  always_comb begin
    smp_l  = '0;
    smp_r  = '0;
    fmt_ok = 1'b1;
    gain   = signed'({1'b0, a_vol_r});
    case (a_fmt_r)
      mvam_pkg::FMT_U8_MONO, mvam_pkg::FMT_U8_STEREO: begin
        smp_l = signed'({9'd0, a_sa_r[7:0]}) - 17'sd128;
        smp_r = signed'({9'd0, a_sb_r[7:0]}) - 17'sd128;
      end
      mvam_pkg::FMT_S8_MONO, mvam_pkg::FMT_S8_STEREO: begin
        smp_l = 17'(signed'(a_sa_r[7:0]));
        smp_r = 17'(signed'(a_sb_r[7:0]));
      end
      mvam_pkg::FMT_S16_MONO, mvam_pkg::FMT_S16_STEREO: begin
        smp_l = 17'(signed'(a_sa_r));
        smp_r = 17'(signed'(a_sb_r));
        gain  = signed'({9'd0, a_vol_r[19:8]});
      end
      default: begin
        fmt_ok = 1'b0;
      end
    endcase
    if (a_fmt_r == mvam_pkg::FMT_U8_MONO || a_fmt_r == mvam_pkg::FMT_S8_MONO ||
        a_fmt_r == mvam_pkg::FMT_S16_MONO) begin
      smp_r = smp_l;
    end
  end

  assign prod_l = smp_l * gain;
  assign prod_r = smp_r * gain;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[a_vidx_r] <= pos_nxt;
    end
    if (in_acc) begin
      a_rd_data_r <= pos_mem[vidx_in];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= '0;
    end else if (wr_en) begin
      pos_vld_r[a_vidx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_voice_r    <= in_voice;
      a_vidx_r     <= vidx_in;
      a_restart_r  <= in_restart;
      a_sa_r       <= in_sample_a;
      a_sb_r       <= in_sample_b;
      a_fmt_r      <= in_source_format;
      a_vol_r      <= in_volume;
      a_step_r     <= in_rate_step;
      a_len_r      <= in_length;
      a_last_r     <= in_last_voice;
      a_rd_vld_r   <= pos_vld_r[vidx_in];
      a_fwd_r      <= wr_en && (a_vidx_r == vidx_in);
      a_fwd_data_r <= pos_nxt;
    end
  end

  // ---------------------------------------------------------------- stage B
  logic [3:0]      b_voice_r;
  mvam_pkg::pos_t  b_pos_r;
  logic [23:0]     b_len_r;
  logic            b_last_r;
  mvam_pkg::prod_t b_prod_l_r;
  mvam_pkg::prod_t b_prod_r_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      b_voice_r  <= a_voice_r;
      b_pos_r    <= pos_nxt;
      b_len_r    <= a_len_r;
      b_last_r   <= a_last_r;
      b_prod_l_r <= (active && fmt_ok) ? prod_l[mvam_pkg::PROD_W-1:0] : '0;
      b_prod_r_r <= (active && fmt_ok) ? prod_r[mvam_pkg::PROD_W-1:0] : '0;
    end
  end

  function automatic mvam_pkg::acc_t sat_add(mvam_pkg::acc_t a, mvam_pkg::prod_t p);
    logic signed [mvam_pkg::ACC_W:0] s;
    s = 41'(a) + 41'(p);
    if (s[mvam_pkg::ACC_W] != s[mvam_pkg::ACC_W-1]) begin
      return s[mvam_pkg::ACC_W] ? mvam_pkg::ACC_MIN : mvam_pkg::ACC_MAX;
    end
    return s[mvam_pkg::ACC_W-1:0];
  endfunction

  mvam_pkg::acc_t sum_l_r;
  mvam_pkg::acc_t sum_r_r;
  mvam_pkg::acc_t sum_l_nxt;
  mvam_pkg::acc_t sum_r_nxt;
  logic           b_adv;
  mvam_pkg::pos_t b_ipart;

  assign sum_l_nxt = sat_add(sum_l_r, b_prod_l_r);
  assign sum_r_nxt = sat_add(sum_r_r, b_prod_r_r);
  assign b_adv     = b_valid_r && adv;
  assign b_ipart   = b_pos_r >> POS_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_l_r <= '0;
      sum_r_r <= '0;
    end else if (b_adv) begin
      sum_l_r <= b_last_r ? '0 : sum_l_nxt;
      sum_r_r <= b_last_r ? '0 : sum_r_nxt;
    end
  end

  // ---------------------------------------------------------------- stage C
  logic [3:0]     c_voice_r;
  logic [23:0]    c_next_index_r;
  logic           c_done_r;
  logic           c_last_r;
  mvam_pkg::acc_t c_sum_l_r;
  mvam_pkg::acc_t c_sum_r_r;

  always_ff @(posedge clk) begin
    if (b_adv) begin
      c_voice_r      <= b_voice_r;
      c_next_index_r <= (b_ipart > 40'hFF_FFFF) ? 24'hFF_FFFF : b_ipart[23:0];
      c_done_r       <= b_ipart >= 40'(b_len_r);
      c_last_r       <= b_last_r;
      c_sum_l_r      <= sum_l_nxt;
      c_sum_r_r      <= sum_r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  function automatic mvam_pkg::mix_t clamp24(mvam_pkg::acc_t x);
    if (x < mvam_pkg::MIX_MIN) begin
      return mvam_pkg::MIX_MIN[mvam_pkg::MIX_W-1:0];
    end
    if (x > mvam_pkg::MIX_MAX) begin
      return mvam_pkg::MIX_MAX[mvam_pkg::MIX_W-1:0];
    end
    return x[mvam_pkg::MIX_W-1:0];
  endfunction

  mvam_pkg::mix_t     cl;
  mvam_pkg::mix_t     cr;
  logic signed [24:0] mono;
  logic [15:0]        fmt_l;
  logic [15:0]        fmt_r;

  always_comb begin
    cl    = clamp24(c_sum_l_r);
    cr    = clamp24(c_sum_r_r);
    mono  = 25'(cl) + 25'(cr);
    fmt_l = '0;
    fmt_r = '0;
    case (mix_format_r)
      mvam_pkg::FMT_U8_MONO: begin
        fmt_l = {8'd0, mono[24:17] + mvam_pkg::U8_BIAS};
      end
      mvam_pkg::FMT_U8_STEREO: begin
        fmt_l = {8'd0, cl[23:16] + mvam_pkg::U8_BIAS};
        fmt_r = {8'd0, cr[23:16] + mvam_pkg::U8_BIAS};
      end
      mvam_pkg::FMT_S8_MONO: begin
        fmt_l = {8'd0, mono[24:17]};
      end
      mvam_pkg::FMT_S8_STEREO: begin
        fmt_l = {8'd0, cl[23:16]};
        fmt_r = {8'd0, cr[23:16]};
      end
      mvam_pkg::FMT_S16_MONO: begin
        fmt_l = mono[24:9];
      end
      mvam_pkg::FMT_S16_STEREO: begin
        fmt_l = cl[23:8];
        fmt_r = cr[23:8];
      end
      default: begin
        fmt_l = '0;
        fmt_r = '0;
      end
    endcase
  end

  assign out_valid       = c_valid_r;
  assign out_voice_echo  = c_voice_r;
  assign out_next_index  = c_next_index_r;
  assign out_voice_done  = c_done_r;
  assign out_frame_valid = c_last_r;
  assign out_left        = c_last_r ? fmt_l : 16'd0;
  assign out_right       = c_last_r ? fmt_r : 16'd0;

endmodule

// ----- src/mvam_checker.sv -----
// ----------------------------------------------------------------------------
// mvam_checker
// Port-level checks of the mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_voice_audio_mixer_top_defines.svh"

module mvam_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_voice_echo,
  input logic [23:0] out_next_index,
  input logic        out_voice_done,
  input logic        out_frame_valid,
  input logic [15:0] out_left,
  input logic [15:0] out_right
);

  `MVAM_ASSERT_RST(a_rst_empty, !out_valid, "result item present right after reset")

  `MVAM_ASSERT_IMP(a_no_frame_zero, out_valid && !out_frame_valid, (out_left == 16'd0) && (out_right == 16'd0), "frame data on a non-closing item")

  `MVAM_ASSERT_IMP(a_open_index, out_valid && !out_voice_done, out_next_index != 24'hFF_FFFF, "saturated index on an unfinished voice")

  `MVAM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_voice_echo) && $stable(out_next_index) && $stable(out_left) && $stable(out_right), "stalled result item changed")

endmodule

bind multi_voice_audio_mixer_top mvam_checker u_mvam_checker (.*);
